FILE: design/yuvrgb_pkg.sv
`default_nettype none

package yuvrgb_pkg;

  // Chroma coefficients in thousandths
  localparam int CoefRMilli  = 1402;
  localparam int CoefGbMilli = 344;
  localparam int CoefGrMilli = 714;
  localparam int CoefBMilli  = 1772;
  localparam int ChromaBias  = 128;

  localparam int PixW     = 8;
  localparam int OffW     = 9;   // widest offset is -226..225
  localparam int SumW     = 11;  // luma plus offsets spans -226..480
  localparam int SlotW    = 2;
  localparam int NumSlots = 3;
  localparam int NumPix   = 4;

  localparam logic [7:0] ScaleNum = 8'd220;
  localparam int ScaleShift       = 8;
  localparam logic [PixW-1:0] PixMax = 8'd255;

  typedef enum logic [1:0] {
    REG_RED_SLOT   = 2'd0,
    REG_GREEN_SLOT = 2'd1,
    REG_BLUE_SLOT  = 2'd2
  } reg_idx_e;

  typedef logic signed [OffW-1:0] off_t;
  typedef off_t rom_t [256];

  typedef struct packed {
    logic [PixW-1:0] luma_top_left;
    logic [PixW-1:0] luma_top_right;
    logic [PixW-1:0] luma_bottom_left;
    logic [PixW-1:0] luma_bottom_right;
    logic [PixW-1:0] chroma_red;
    logic [PixW-1:0] chroma_blue;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0] top_left_byte0;
    logic [PixW-1:0] top_left_byte1;
    logic [PixW-1:0] top_left_byte2;
    logic [PixW-1:0] top_right_byte0;
    logic [PixW-1:0] top_right_byte1;
    logic [PixW-1:0] top_right_byte2;
    logic [PixW-1:0] bottom_left_byte0;
    logic [PixW-1:0] bottom_left_byte1;
    logic [PixW-1:0] bottom_left_byte2;
    logic [PixW-1:0] bottom_right_byte0;
    logic [PixW-1:0] bottom_right_byte1;
    logic [PixW-1:0] bottom_right_byte2;
  } out_item_t;

  typedef struct packed {
    logic [SlotW-1:0] red;
    logic [SlotW-1:0] green;
    logic [SlotW-1:0] blue;
  } slot_cfg_t;

  typedef struct packed {
    off_t r;
    off_t gr;
    off_t gb;
    off_t b;
  } chroma_off_t;

  // Elaboration-time table build; C-style signed divide truncates toward zero.
  function automatic rom_t build_rom(int kmilli);
    rom_t rom;
    int   d;
    for (int i = 0; i < 256; i++) begin
      d      = i - ChromaBias;
      rom[i] = OffW'((kmilli * d) / 1000);
    end
    return rom;
  endfunction

  localparam rom_t RomR  = build_rom(CoefRMilli);
  localparam rom_t RomGr = build_rom(CoefGrMilli);
  localparam rom_t RomGb = build_rom(CoefGbMilli);
  localparam rom_t RomB  = build_rom(CoefBMilli);

endpackage

`default_nettype wire

FILE: design/yuv420_block_to_rgb_top.sv
`default_nettype none

// YCbCr 4:2:0 to RGB block converter (BT.601 style coefficients). Each input
// transfer carries one 2x2 luma block with its shared Cr and Cb samples; each
// output transfer carries twelve bytes, three per pixel, in the order top
// left, top right, bottom left, bottom right. Channels are luma plus a chroma
// offset from constant tables (trunc of 1.402, 0.344, 0.714, 1.772 times
// chroma-128); green is luma minus two offsets. Sums above 255 give 255, below
// 0 give 0, the rest are scaled by 220/256. The cfg port places red, green and
// blue into byte slots 0..2 (index 0 red, 1 green, 2 blue; reset 2/1/0);
// on a clash red beats green beats blue, an unnamed slot reads 0 and a slot
// value of 3 drops that channel. Write cfg only while the block is empty.
// Throughput is one block per clock while the output is not stalled. A block
// passes an input register, then the table lookup, add, clip/scale and slot
// mux into the output register, which drives the output channel. Output
// stall stalls the input only when both registers are full.
module yuv420_block_to_rgb_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration writes
  input  wire logic                           cfg_we_i,
  input  wire logic [1:0]                     cfg_idx_i,
  input  wire logic [yuvrgb_pkg::SlotW-1:0]   cfg_data_i,
  // input channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire yuvrgb_pkg::in_item_t           in_data_i,
  // output channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output yuvrgb_pkg::out_item_t               out_data_o
);

  yuvrgb_pkg::slot_cfg_t   slot_q;
  yuvrgb_pkg::in_item_t    in_q;
  logic                    in_valid_q;
  yuvrgb_pkg::out_item_t   out_q, out_d;
  logic                    out_valid_q;
  logic                    out_free;
  logic                    in_take;
  yuvrgb_pkg::chroma_off_t off;
  logic [yuvrgb_pkg::NumPix-1:0][yuvrgb_pkg::PixW-1:0] luma;
  logic [yuvrgb_pkg::NumPix-1:0][yuvrgb_pkg::NumSlots-1:0][yuvrgb_pkg::PixW-1:0] px_bytes;

  // Slot registers; index 3 has no register and is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q.red   <= 2'd2;
      slot_q.green <= 2'd1;
      slot_q.blue  <= 2'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        yuvrgb_pkg::REG_RED_SLOT:   slot_q.red   <= cfg_data_i;
        yuvrgb_pkg::REG_GREEN_SLOT: slot_q.green <= cfg_data_i;
        yuvrgb_pkg::REG_BLUE_SLOT:  slot_q.blue  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Output register frees when empty or its transfer completes this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (out_free && in_valid_q) begin
      out_q <= out_d;
    end
  end

  yuvrgb_chroma u_chroma (
    .cr_i  (in_q.chroma_red),
    .cb_i  (in_q.chroma_blue),
    .off_o (off)
  );

  assign luma[0] = in_q.luma_top_left;
  assign luma[1] = in_q.luma_top_right;
  assign luma[2] = in_q.luma_bottom_left;
  assign luma[3] = in_q.luma_bottom_right;

  for (genvar p = 0; p < yuvrgb_pkg::NumPix; p++) begin : g_pix
    yuvrgb_pixel u_pixel (
      .luma_i  (luma[p]),
      .off_i   (off),
      .slot_i  (slot_q),
      .bytes_o (px_bytes[p])
    );
  end

  always_comb begin
    out_d.top_left_byte0     = px_bytes[0][0];
    out_d.top_left_byte1     = px_bytes[0][1];
    out_d.top_left_byte2     = px_bytes[0][2];
    out_d.top_right_byte0    = px_bytes[1][0];
    out_d.top_right_byte1    = px_bytes[1][1];
    out_d.top_right_byte2    = px_bytes[1][2];
    out_d.bottom_left_byte0  = px_bytes[2][0];
    out_d.bottom_left_byte1  = px_bytes[2][1];
    out_d.bottom_left_byte2  = px_bytes[2][2];
    out_d.bottom_right_byte0 = px_bytes[3][0];
    out_d.bottom_right_byte1 = px_bytes[3][1];
    out_d.bottom_right_byte2 = px_bytes[3][2];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: design/yuvrgb_chroma.sv
`default_nettype none

// Chroma offset lookup, shared by all four pixels of the block.
module yuvrgb_chroma (
  input  wire logic [yuvrgb_pkg::PixW-1:0] cr_i,
  input  wire logic [yuvrgb_pkg::PixW-1:0] cb_i,
  output yuvrgb_pkg::chroma_off_t          off_o
);

  always_comb begin
    off_o.r  = yuvrgb_pkg::RomR[cr_i];
    off_o.gr = yuvrgb_pkg::RomGr[cr_i];
    off_o.gb = yuvrgb_pkg::RomGb[cb_i];
    off_o.b  = yuvrgb_pkg::RomB[cb_i];
  end

endmodule

`default_nettype wire

FILE: design/yuvrgb_pixel.sv
`default_nettype none

// One pixel: add offsets, clip/scale, place channels into byte slots.
module yuvrgb_pixel (
  input  wire logic [yuvrgb_pkg::PixW-1:0]                 luma_i,
  input  wire yuvrgb_pkg::chroma_off_t                     off_i,
  input  wire yuvrgb_pkg::slot_cfg_t                       slot_i,
  output logic [yuvrgb_pkg::NumSlots-1:0][yuvrgb_pkg::PixW-1:0] bytes_o
);

  localparam int SumW = yuvrgb_pkg::SumW;
  localparam int PixW = yuvrgb_pkg::PixW;
  localparam int OffW = yuvrgb_pkg::OffW;

  logic signed [SumW-1:0] y_s, r_sum, g_sum, b_sum;
  logic [PixW-1:0]        r_px, g_px, b_px;

  function automatic logic signed [SumW-1:0] sext(logic signed [OffW-1:0] v);
    return $signed({{(SumW-OffW){v[OffW-1]}}, v});
  endfunction

  // Above 255 saturates unscaled, below 0 is 0, the rest is v*220/256.
  function automatic logic [PixW-1:0] clip_scale(logic signed [SumW-1:0] v);
    logic [2*PixW-1:0] prod;
    logic [PixW-1:0]   clipped;
    clipped = v[PixW-1:0];
    prod    = clipped * yuvrgb_pkg::ScaleNum;
    if (v > $signed({{(SumW-PixW){1'b0}}, yuvrgb_pkg::PixMax})) begin
      return yuvrgb_pkg::PixMax;
    end else if (v[SumW-1]) begin
      return '0;
    end else begin
      return prod[yuvrgb_pkg::ScaleShift +: PixW];
    end
  endfunction

  always_comb begin
    y_s   = $signed({{(SumW-PixW){1'b0}}, luma_i});
    r_sum = y_s + sext(off_i.r);
    g_sum = y_s - sext(off_i.gb) - sext(off_i.gr);
    b_sum = y_s + sext(off_i.b);
    r_px  = clip_scale(r_sum);
    g_px  = clip_scale(g_sum);
    b_px  = clip_scale(b_sum);
  end

  // Red over green over blue; an unnamed slot stays 0.
  always_comb begin
    for (int s = 0; s < yuvrgb_pkg::NumSlots; s++) begin
      priority if (slot_i.red == yuvrgb_pkg::SlotW'(s)) begin
        bytes_o[s] = r_px;
      end else if (slot_i.green == yuvrgb_pkg::SlotW'(s)) begin
        bytes_o[s] = g_px;
      end else if (slot_i.blue == yuvrgb_pkg::SlotW'(s)) begin
        bytes_o[s] = b_px;
      end else begin
        bytes_o[s] = '0;
      end
    end
  end

endmodule

`default_nettype wire
